// File: rtl/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  localparam int CoordBits  = 12;
  localparam int DeltaBits  = CoordBits + 1;
  localparam int ErrBits    = CoordBits + 2;
  localparam int QueueDepth = 2;

  localparam logic signed [CoordBits-1:0] WinLow  = -CoordBits'(200);
  localparam logic signed [CoordBits-1:0] WinHigh = CoordBits'(900);

  typedef enum logic {
    ActLoad = 1'b0,
    ActStep = 1'b1
  } action_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [DeltaBits-1:0]        delta_t;
  typedef logic signed [ErrBits-1:0]   err_t;

  typedef struct packed {
    logic   action;
    coord_t x_start;
    coord_t x_end;
    coord_t y_start;
    coord_t y_end;
    logic   drive_axis;
  } lr_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   in_window;
    logic   last_pixel;
  } lr_out_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    action_e kind;
    logic    axis_sel;
    coord_t  major_start;
    coord_t  major_stop;
    coord_t  minor_start;
    delta_t  major_delta;
    delta_t  minor_delta;
    logic    minor_decreasing;
    logic    line_ok;
    err_t    err_init;
  } lr_cmd_t;

endpackage

// File: rtl/lr_front.sv
`timescale 1ns / 1ps

module lr_front import lr_pkg::*; (
  input  logic    in_valid_i,
  input  lr_in_t  in_data_i,
  output logic    in_stall_o,
  input  logic    q_full_i,
  output logic    q_push_o,
  output lr_cmd_t q_data_o
);

  coord_t                     maj_s;
  coord_t                     maj_e;
  coord_t                     min_s;
  coord_t                     min_e;
  logic signed [DeltaBits-1:0] dmin;
  logic signed [DeltaBits-1:0] dmaj;
  delta_t                     min_abs;
  delta_t                     maj_del;
  logic                       ok;

  always_comb begin
    if (in_data_i.drive_axis) begin
      maj_s = in_data_i.y_start;
      maj_e = in_data_i.y_end;
      min_s = in_data_i.x_start;
      min_e = in_data_i.x_end;
    end else begin
      maj_s = in_data_i.x_start;
      maj_e = in_data_i.x_end;
      min_s = in_data_i.y_start;
      min_e = in_data_i.y_end;
    end
  end

  assign dmin    = DeltaBits'(min_e) - DeltaBits'(min_s);
  assign dmaj    = DeltaBits'(maj_e) - DeltaBits'(maj_s);
  assign min_abs = dmin[DeltaBits-1] ? delta_t'(-dmin) : delta_t'(dmin);
  assign ok      = maj_e > maj_s;
  assign maj_del = ok ? delta_t'(dmaj) : '0;

  always_comb begin
    q_data_o                  = '0;
    q_data_o.kind             = action_e'(in_data_i.action);
    q_data_o.axis_sel         = in_data_i.drive_axis;
    q_data_o.major_start      = maj_s;
    q_data_o.major_stop       = maj_e;
    q_data_o.minor_start      = min_s;
    q_data_o.major_delta      = maj_del;
    q_data_o.minor_delta      = min_abs;
    q_data_o.minor_decreasing = dmin[DeltaBits-1];
    q_data_o.line_ok          = ok;
    // Both deltas stay below 2**CoordBits, so the start value fits without saturation.
    q_data_o.err_init         = ErrBits'({1'b0, min_abs}) - ErrBits'({1'b0, maj_del});
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// File: rtl/lr_queue.sv
`timescale 1ns / 1ps

module lr_queue import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  lr_cmd_t push_data_i,
  output logic    full_o,
  output logic    pop_valid_o,
  output lr_cmd_t pop_data_o,
  input  logic    pop_i
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  lr_cmd_t              mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 do_pop;

  assign full_o      = count_q == CntBits'(QueueDepth);
  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/lr_back.sv
`timescale 1ns / 1ps

module lr_back import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  lr_cmd_t cmd_i,
  output logic    cmd_pop_o,
  output logic    out_valid_o,
  output lr_out_t out_data_o,
  input  logic    out_stall_i
);

  localparam int WideBits = ErrBits + 2;

  coord_t  major_pos_q, major_pos_d;
  coord_t  minor_pos_q, minor_pos_d;
  err_t    err_q, err_d;
  coord_t  major_stop_q, major_stop_d;
  delta_t  major_delta_q, major_delta_d;
  delta_t  minor_delta_q, minor_delta_d;
  logic    minor_dec_q, minor_dec_d;
  logic    axis_q, axis_d;
  logic    running_q, running_d;
  logic    out_valid_q, out_valid_d;
  lr_out_t out_q, out_d;

  logic    is_step;
  logic    slot_free;
  coord_t  px, py;
  coord_t  major_next;
  err_t    err_mid;
  logic signed [WideBits-1:0] sub_w;
  logic signed [WideBits-1:0] add_w;

  function automatic err_t sat_err(logic signed [WideBits-1:0] v);
    err_t r;
    if (v > WideBits'(2 ** (ErrBits - 1) - 1)) begin
      r = {1'b0, {(ErrBits - 1){1'b1}}};
    end else if (v < -WideBits'(2 ** (ErrBits - 1))) begin
      r = {1'b1, {(ErrBits - 1){1'b0}}};
    end else begin
      r = v[ErrBits-1:0];
    end
    return r;
  endfunction

  assign is_step   = cmd_i.kind == ActStep;
  assign slot_free = !out_valid_q || !out_stall_i;
  // A load makes no result, so it leaves the queue even while the output waits.
  assign cmd_pop_o = cmd_valid_i && (!is_step || slot_free);

  assign px         = axis_q ? minor_pos_q : major_pos_q;
  assign py         = axis_q ? major_pos_q : minor_pos_q;
  assign major_next = major_pos_q + 1'b1;

  assign sub_w   = WideBits'(err_q) - WideBits'({1'b0, major_delta_q});
  assign err_mid = err_q[ErrBits-1] ? err_q : sat_err(sub_w);
  assign add_w   = WideBits'(err_mid) + WideBits'({1'b0, minor_delta_q});

  always_comb begin
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    err_d         = err_q;
    major_stop_d  = major_stop_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    minor_dec_d   = minor_dec_q;
    axis_d        = axis_q;
    running_d     = running_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;

    if (cmd_pop_o) begin
      if (!is_step) begin
        major_pos_d   = cmd_i.major_start;
        minor_pos_d   = cmd_i.minor_start;
        err_d         = cmd_i.err_init;
        major_stop_d  = cmd_i.major_stop;
        major_delta_d = cmd_i.major_delta;
        minor_delta_d = cmd_i.minor_delta;
        minor_dec_d   = cmd_i.minor_decreasing;
        axis_d        = cmd_i.axis_sel;
        running_d     = cmd_i.line_ok;
      end else begin
        out_valid_d = 1'b1;
        out_d       = '0;
        if (running_q) begin
          out_d.pixel_x     = px;
          out_d.pixel_y     = py;
          out_d.pixel_valid = 1'b1;
          out_d.in_window   = (px > WinLow) && (px < WinHigh) &&
                              (py > WinLow) && (py < WinHigh);
          out_d.last_pixel  = major_next == major_stop_q;
          if (!err_q[ErrBits-1]) begin
            minor_pos_d = minor_dec_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
          end
          err_d       = sat_err(add_w);
          major_pos_d = major_next;
          running_d   = !(major_next >= major_stop_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q   <= '0;
      minor_pos_q   <= '0;
      err_q         <= '0;
      major_stop_q  <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      minor_dec_q   <= 1'b0;
      axis_q        <= 1'b0;
      running_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      err_q         <= err_d;
      major_stop_q  <= major_stop_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      minor_dec_q   <= minor_dec_d;
      axis_q        <= axis_d;
      running_q     <= running_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/line_rasterizer_core.sv
`timescale 1ns / 1ps
// A step item is written into the queue; its pixel is then registered by the stepping unit.
// One item per cycle while no stall holds it; a step is a subtract, add, compare and increment.
// A load item produces no transfer on the output side.
// A two-entry queue separates input classification from the stepping unit.
// Reset (rst_ni low, asynchronous) empties the queue, drops the output and leaves no line active.
module line_rasterizer_core import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  lr_in_t  in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output lr_out_t out_data_o,
  input  logic    out_stall_i
);

  logic    q_full;
  logic    q_push;
  lr_cmd_t q_in;
  logic    q_valid;
  lr_cmd_t q_out;
  logic    q_pop;

  lr_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  lr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_out),
    .pop_i       (q_pop)
  );

  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: rtl/lr_checker.sv
`timescale 1ns / 1ps

module lr_checker import lr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input lr_out_t out_data_o,
  input logic    out_stall_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A step past the end of the line reports an all-zero result.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pixel_valid |->
      out_data_o.pixel_x == '0 && out_data_o.pixel_y == '0 &&
      !out_data_o.in_window && !out_data_o.last_pixel)
    else $error("invalid pixel carries nonzero fields");

  a_window_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_window |->
      out_data_o.pixel_valid &&
      out_data_o.pixel_x > WinLow && out_data_o.pixel_x < WinHigh &&
      out_data_o.pixel_y > WinLow && out_data_o.pixel_y < WinHigh)
    else $error("window flag disagrees with pixel coordinates");

  // The end of a line is only ever flagged on a drawn pixel.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_pixel |-> out_data_o.pixel_valid)
    else $error("last pixel flag on a result without a pixel");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);

// File: tb/sv/line_rasterizer_checker.sv
`timescale 1ns / 1ps
module line_rasterizer_checker import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_stall_i,
  input  lr_in_t  in_data_i,
  input  logic    out_valid_i,
  input  logic    out_stall_i,
  input  lr_out_t out_data_i,
  output int      fail_cnt_o,
  output int      pending_o,
  output int      pixel_cnt_o,
  output int      last_cnt_o
);

  localparam int ErrMax = 2 ** (ErrBits - 1) - 1;
  localparam int ErrMin = -(2 ** (ErrBits - 1));

  // Line state as the stepping unit should hold it.
  coord_t  cur_major;
  coord_t  cur_minor;
  coord_t  stop_major;
  int      err_acc;
  int      span_major;
  int      span_minor;
  logic    minor_down;
  logic    y_major;
  logic    line_live;

  lr_out_t pending_pixels[$];
  int      fail_cnt;
  int      pixel_cnt;
  int      last_cnt;

  function automatic int clamp_err(int v);
    if (v > ErrMax) return ErrMax;
    if (v < ErrMin) return ErrMin;
    return v;
  endfunction

  function automatic logic in_frame(int v);
    return v > int'(WinLow) && v < int'(WinHigh);
  endfunction

  task automatic latch_line(lr_in_t it);
    int d_minor;
    y_major = it.drive_axis;
    if (!y_major) begin
      cur_major  = it.x_start;
      stop_major = it.x_end;
      cur_minor  = it.y_start;
      d_minor    = int'(it.y_end) - int'(it.y_start);
    end else begin
      cur_major  = it.y_start;
      stop_major = it.y_end;
      cur_minor  = it.x_start;
      d_minor    = int'(it.x_end) - int'(it.x_start);
    end
    minor_down = d_minor < 0;
    span_minor = minor_down ? -d_minor : d_minor;
    line_live  = stop_major > cur_major;
    span_major = line_live ? int'(stop_major) - int'(cur_major) : 0;
    err_acc    = clamp_err(span_minor - span_major);
  endtask

  task automatic advance_pixel(output lr_out_t px_o);
    px_o = '0;
    if (!line_live) return;
    px_o.pixel_x     = y_major ? cur_minor : cur_major;
    px_o.pixel_y     = y_major ? cur_major : cur_minor;
    px_o.pixel_valid = 1'b1;
    px_o.in_window   = in_frame(int'(px_o.pixel_x)) && in_frame(int'(px_o.pixel_y));
    px_o.last_pixel  = (int'(cur_major) + 1 == int'(stop_major));
    // The minor coordinate moves first, then the slope is added back in.
    if (err_acc >= 0) begin
      cur_minor = minor_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
      err_acc   = clamp_err(err_acc - span_major);
    end
    err_acc   = clamp_err(err_acc + span_minor);
    cur_major = cur_major + 1'b1;
    if (cur_major >= stop_major) line_live = 1'b0;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    lr_out_t want;
    if (!rst_ni) begin
      cur_major  = '0;
      cur_minor  = '0;
      stop_major = '0;
      err_acc    = 0;
      span_major = 0;
      span_minor = 0;
      minor_down = 1'b0;
      y_major    = 1'b0;
      line_live  = 1'b0;
      pending_pixels.delete();
    end else begin
      // Outputs first: a pixel leaving now never belongs to an item entering now.
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel transfer, expected none, actual x=%0d y=%0d v=%0b w=%0b l=%0b",
                   $time, out_data_i.pixel_x, out_data_i.pixel_y, out_data_i.pixel_valid,
                   out_data_i.in_window, out_data_i.last_pixel);
          fail_cnt++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", want.pixel_x, out_data_i.pixel_x);
          check_field("pixel_y", want.pixel_y, out_data_i.pixel_y);
          check_field("pixel_valid", want.pixel_valid, out_data_i.pixel_valid);
          check_field("in_window", want.in_window, out_data_i.in_window);
          check_field("last_pixel", want.last_pixel, out_data_i.last_pixel);
          if (want.pixel_valid) pixel_cnt++;
          if (want.last_pixel) last_cnt++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.action == ActLoad) begin
          latch_line(in_data_i);
        end else begin
          advance_pixel(want);
          pending_pixels.push_back(want);
        end
      end
    end
    fail_cnt_o  <= fail_cnt;
    pending_o   <= pending_pixels.size();
    pixel_cnt_o <= pixel_cnt;
    last_cnt_o  <= last_cnt;
  end

endmodule

// File: tb/sv/line_rasterizer_core_test.sv
`timescale 1ns / 1ps
module line_rasterizer_core_test;
  import lr_pkg::*;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  lr_in_t  in_data   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  lr_out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int load_cnt      = 0;
  int step_cnt      = 0;
  int fail_cnt;
  int pending_cnt;
  int pixel_cnt;
  int last_cnt;

  line_rasterizer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  line_rasterizer_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .pixel_cnt_o (pixel_cnt),
    .last_cnt_o  (last_cnt)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(lr_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.action == ActLoad) load_cnt++;
    else step_cnt++;
  endtask

  function automatic lr_in_t line_item(int xs, int xe, int ys, int ye, logic axis);
    lr_in_t it;
    it.action     = ActLoad;
    it.x_start    = coord_t'(xs);
    it.x_end      = coord_t'(xe);
    it.y_start    = coord_t'(ys);
    it.y_end      = coord_t'(ye);
    it.drive_axis = axis;
    return it;
  endfunction

  // Step items carry random coordinates, which the block must ignore.
  task automatic send_steps(int n);
    logic [63:0] raw;
    lr_in_t      it;
    repeat (n) begin
      raw       = {$urandom(), $urandom()};
      it        = raw[$bits(lr_in_t)-1:0];
      it.action = ActStep;
      send_item(it);
    end
  endtask

  function automatic int clip_coord(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // Coordinates cluster around both window edges, with some across the window and some from the full range.
  function automatic int pick_coord();
    case ($urandom_range(3))
      0:       return int'($urandom_range(4095)) - 2048;
      1:       return int'($urandom_range(210)) - 305;
      2:       return int'($urandom_range(210)) + 795;
      default: return int'($urandom_range(1300)) - 300;
    endcase
  endfunction

  task automatic random_line();
    logic        axis;
    int          kind;
    int          span;
    int          maj_s;
    int          maj_e;
    int          min_s;
    int          min_e;
    int          n_steps;
    logic [63:0] raw;
    lr_in_t      it;
    axis  = 1'($urandom_range(1));
    kind  = $urandom_range(19);
    maj_s = pick_coord();
    min_s = pick_coord();
    if (kind == 0) begin
      // Fully random load, mostly unordered or very long.
      raw       = {$urandom(), $urandom()};
      it        = raw[$bits(lr_in_t)-1:0];
      it.action = ActLoad;
      send_item(it);
      send_steps($urandom_range(3));
      return;
    end
    if (kind <= 2) span = -int'($urandom_range(20));
    else if (kind <= 4) span = int'($urandom_range(4095));
    else span = 1 + int'($urandom_range(15));
    maj_e = clip_coord(maj_s + span);
    span  = maj_e - maj_s;
    if ($urandom_range(7) == 0) begin
      min_e = clip_coord(min_s + int'($urandom_range(8190)) - 4095);
    end else begin
      min_e = clip_coord(min_s + int'($urandom_range(2 * (span > 0 ? span : 8))) -
                         (span > 0 ? span : 8));
    end
    if (axis) send_item(line_item(min_s, min_e, maj_s, maj_e, axis));
    else send_item(line_item(maj_s, maj_e, min_s, min_e, axis));
    if (span <= 0) n_steps = $urandom_range(2);
    else if ($urandom_range(5) == 0) n_steps = $urandom_range(span > 40 ? 40 : span);
    else n_steps = (span > 40 ? 40 : span) + int'($urandom_range(2));
    send_steps(n_steps);
  endtask

  initial begin
    int wait_cycles;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        // Step before any line, then an empty line.
        send_steps(1);
        send_item(line_item(5, 5, 0, 0, 1'b0));
        send_steps(1);
        // Steep falling minor from the top corner drives the error term to saturation.
        send_item(line_item(-2048, -2045, 2047, -2048, 1'b0));
        send_steps(4);
        // Y-driven line crossing both window edges.
        send_item(line_item(-201, -199, 898, 901, 1'b1));
        send_steps(3);
        // Full-width line cut short by a new load of a single-pixel line.
        send_item(line_item(-2048, 2047, -200, 900, 1'b0));
        send_steps(3);
        send_item(line_item(899, 900, -199, -199, 1'b0));
        send_steps(2);
        // Y-driven line given in reverse order.
        send_item(line_item(0, 0, 2047, -2048, 1'b1));
        send_steps(1);
      end
      while (load_cnt + step_cnt < (ph + 1) * 650) random_line();
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_cnt != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_cnt != 0) $display("%0t: %0d expected pixels never arrived", $time, pending_cnt);

    $display("Sent %0d line loads and %0d step requests over three flow-control phases.",
             load_cnt, step_cnt);
    $display("Checked %0d drawn pixels, %0d of them line ends.", pixel_cnt, last_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
